// ===== hw/rtl/esh_pkg.sv =====
// Shared types, constants and hash helpers for the ELF symbol hash engine.
// No dependencies; every other RTL file of the block imports this package.
package esh_pkg;

  // GNU hash seed, queue sizing and divider sizing
  localparam logic [31:0] GnuSeed = 32'd5381;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned DivBits = 32;
  localparam int unsigned DivCntW = $clog2(DivBits);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SYSV_BUCKETS = 3'd0,
    CFG_GNU_BUCKETS  = 3'd1,
    CFG_BLOOM_WORDS  = 3'd2,
    CFG_BLOOM_SHIFT  = 3'd3
  } cfg_index_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // Finished hashes of one name, as queued between front and back
  typedef struct packed {
    logic [27:0] classic;
    logic [31:0] gnu;
  } item_t;

  // Configuration register set
  typedef struct packed {
    logic [31:0] sysv_count;
    logic [31:0] gnu_count;
    logic [31:0] bloom_count;
    logic [5:0]  bloom_rshift;
  } cfg_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One byte step of the classic ELF hash
  function automatic logic [27:0] classic_update(logic [27:0] h, logic [7:0] b);
    logic [31:0] t;
    logic [31:0] top;
    t   = {h, 4'b0000} + {24'd0, b};
    top = t & 32'hF000_0000;
    t   = t ^ (top >> 24);
    t   = t & ~top;
    return t[27:0];
  endfunction

  // One byte step of the GNU hash: h * 33 + b, modulo 2^32
  function automatic logic [31:0] gnu_update(logic [31:0] h, logic [7:0] b);
    return (h << 5) + h + {24'd0, b};
  endfunction

endpackage

// ===== hw/rtl/esh_front.sv =====
// Front end: running classic and GNU hash accumulators, one byte per cycle while input is accepted.
// Depends on esh_pkg; pushes the finished hashes of each name into esh_queue.
module esh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    name_byte_i,
  input  logic          last_byte_i,
  output logic          push_o,
  output esh_pkg::item_t push_item_o
);
  import esh_pkg::*;

  logic [27:0] classic_q, classic_d;
  logic [31:0] gnu_q, gnu_d;
  logic [27:0] classic_next;
  logic [31:0] gnu_next;

  // Fold the incoming byte into both hashes
  assign classic_next = classic_update(classic_q, name_byte_i);
  assign gnu_next     = gnu_update(gnu_q, name_byte_i);

  // Hand off on the last byte and drop back to the seeds
  always_comb begin
    classic_d = classic_q;
    gnu_d     = gnu_q;
    if (accept_i) begin
      if (last_byte_i) begin
        classic_d = '0;
        gnu_d     = GnuSeed;
      end else begin
        classic_d = classic_next;
        gnu_d     = gnu_next;
      end
    end
  end

  assign push_o              = accept_i & last_byte_i;
  assign push_item_o.classic = classic_next;
  assign push_item_o.gnu     = gnu_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      classic_q <= '0;
      gnu_q     <= GnuSeed;
    end else begin
      classic_q <= classic_d;
      gnu_q     <= gnu_d;
    end
  end

endmodule

// ===== hw/rtl/esh_queue.sv =====
// Short FIFO of finished hash pairs between the front and back ends.
// Depends on esh_pkg for the entry type and depth.
module esh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  esh_pkg::item_t   push_item_i,
  input  logic             pop_i,
  output esh_pkg::item_t   pop_item_o,
  output esh_pkg::q_stat_t stat_o
);
  import esh_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign stat_o.full  = (count_q == QCntW'(QDepth));
  assign stat_o.empty = (count_q == '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/esh_back.sv =====
// Back end: two radix-2 restoring remainder lanes, Bloom terms, output register.
// Depends on esh_pkg; pops hash pairs from esh_queue.
module esh_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  esh_pkg::item_t   q_item_i,
  input  esh_pkg::q_stat_t q_stat_i,
  output logic             q_pop_o,
  input  esh_pkg::cfg_t    cfg_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [27:0]      classic_hash_o,
  output logic [31:0]      gnu_hash_value_o,
  output logic [31:0]      classic_bucket_o,
  output logic [31:0]      gnu_bucket_o,
  output logic [25:0]      bloom_word_sel_o,
  output logic [63:0]      bloom_mask_o,
  output logic             config_error_o
);
  import esh_pkg::*;

  back_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               load_out;

  // Working registers of the two remainder lanes
  item_t       item_q;
  logic [31:0] dvd_c_q, dvd_g_q;
  logic [31:0] rem_c_q, rem_g_q;
  logic [31:0] rem_c_next, rem_g_next;
  logic [32:0] sh_c, sh_g, diff_c, diff_g;

  // One quotient bit per cycle in each lane
  assign sh_c       = {rem_c_q, dvd_c_q[31]};
  assign sh_g       = {rem_g_q, dvd_g_q[31]};
  assign diff_c     = sh_c - {1'b0, cfg_i.sysv_count};
  assign diff_g     = sh_g - {1'b0, cfg_i.gnu_count};
  assign rem_c_next = diff_c[32] ? sh_c[31:0] : diff_c[31:0];
  assign rem_g_next = diff_g[32] ? sh_g[31:0] : diff_g[31:0];

  // Sequence load, iterate and hand off
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    load_out    = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          cnt_d   = '0;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivBits - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load or shift the lanes
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q  <= q_item_i;
      dvd_c_q <= {4'd0, q_item_i.classic};
      dvd_g_q <= q_item_i.gnu;
      rem_c_q <= '0;
      rem_g_q <= '0;
    end else if (state_q == BK_DIV) begin
      dvd_c_q <= {dvd_c_q[30:0], 1'b0};
      dvd_g_q <= {dvd_g_q[30:0], 1'b0};
      rem_c_q <= rem_c_next;
      rem_g_q <= rem_g_next;
    end
  end

  // Bloom terms and configuration check
  logic [31:0] bloom_count_m1;
  logic [31:0] second_word;
  logic [5:0]  first_bit, second_bit;
  logic        shift_bad, err;

  assign bloom_count_m1 = cfg_i.bloom_count - 32'd1;
  assign shift_bad      = cfg_i.bloom_rshift[5];
  assign second_word    = shift_bad ? 32'd0 : (item_q.gnu >> cfg_i.bloom_rshift[4:0]);
  assign first_bit      = item_q.gnu[5:0];
  assign second_bit     = second_word[5:0];
  assign err = (cfg_i.sysv_count == '0) || (cfg_i.gnu_count == '0) ||
               (cfg_i.bloom_count == '0) ||
               ((cfg_i.bloom_count & bloom_count_m1) != '0) || shift_bad;

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      classic_hash_o   <= item_q.classic;
      gnu_hash_value_o <= item_q.gnu;
      classic_bucket_o <= (cfg_i.sysv_count == '0) ? 32'd0 : rem_c_q;
      gnu_bucket_o     <= (cfg_i.gnu_count == '0) ? 32'd0 : rem_g_q;
      bloom_word_sel_o <= item_q.gnu[31:6] & bloom_count_m1[25:0];
      bloom_mask_o     <= (64'd1 << first_bit) | (64'd1 << second_bit);
      config_error_o   <= err;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/elf_symbol_hash_engine_unit.sv =====
// Top level of the ELF symbol hash engine: configuration registers and wiring.
// Depends on esh_pkg, esh_front, esh_queue and esh_back.
//
//  port group   direction  flow control           payload
//  in_*         input      in_valid_i/in_stall_o  name_byte_i, last_byte_i
//  out_*        output     out_valid_o/out_stall_i  hashes, buckets, Bloom, error
//  cfg_*        input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Bytes are taken one per cycle while the two-entry name queue has room.
// Each name then passes through the back end in turn: one load, one remainder
// step per dividend bit in the bit-serial bucket lanes, and one output load; that loop sets the
// name rate. Reset returns the seeds, the registers' reset values and an
// empty queue. A stalled output holds the back end in its done state.
module elf_symbol_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  name_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [27:0] classic_hash_o,
  output logic [31:0] gnu_hash_value_o,
  output logic [31:0] classic_bucket_o,
  output logic [31:0] gnu_bucket_o,
  output logic [25:0] bloom_word_sel_o,
  output logic [63:0] bloom_mask_o,
  output logic        config_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import esh_pkg::*;

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  item_t   push_item, pop_item;
  logic    in_accept, q_push, q_pop;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SYSV_BUCKETS: cfg_d.sysv_count   = cfg_data_i;
        CFG_GNU_BUCKETS:  cfg_d.gnu_count    = cfg_data_i;
        CFG_BLOOM_WORDS:  cfg_d.bloom_count  = cfg_data_i;
        CFG_BLOOM_SHIFT:  cfg_d.bloom_rshift = cfg_data_i[5:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sysv_count   <= 32'd1;
      cfg_q.gnu_count    <= 32'd1;
      cfg_q.bloom_count  <= 32'd1;
      cfg_q.bloom_rshift <= 6'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stall input while the queue is full
  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i & ~in_stall_o;

  esh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .name_byte_i (name_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (q_push),
    .push_item_o (push_item)
  );

  esh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  esh_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_item_i         (pop_item),
    .q_stat_i         (q_stat),
    .q_pop_o          (q_pop),
    .cfg_i            (cfg_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .classic_hash_o   (classic_hash_o),
    .gnu_hash_value_o (gnu_hash_value_o),
    .classic_bucket_o (classic_bucket_o),
    .gnu_bucket_o     (gnu_bucket_o),
    .bloom_word_sel_o (bloom_word_sel_o),
    .bloom_mask_o     (bloom_mask_o),
    .config_error_o   (config_error_o)
  );

  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_stat.full))
    else $error("name queue overflow");

  // The back end pops only a filled queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("pop from empty name queue");

  // The back end never pops two names in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |=> !q_pop)
    else $error("back end popped two names in a row");

endmodule
